// File: sv/vector_angle_magnitude_core_assert.svh
// ----------------------------------------------------------------------------
// Vector angle/magnitude core assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_MAGNITUDE_CORE_ASSERT_SVH
`define VECTOR_ANGLE_MAGNITUDE_CORE_ASSERT_SVH

// Generic property check
`define VAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication check
`define VAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/vam_pkg.sv
// ----------------------------------------------------------------------------
// Vector angle/magnitude package
// Shared constants, defaults and the octant flag type.
// ----------------------------------------------------------------------------
package vam_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned RATIO_STEPS  = 1024;

  localparam int unsigned ANGLE_WIDTH = 16;
  localparam int unsigned AMP_WIDTH   = 16;
  localparam int unsigned ATAN_WIDTH  = 14;
  localparam int unsigned MAG_WIDTH   = 16;
  localparam int unsigned FRAC_BITS   = 15;

  localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = 16'h4000;
  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = 16'h8000;
  localparam logic [ANGLE_WIDTH-1:0] ANG_3QUART  = 16'hC000;

  typedef struct packed {
    logic swap;  // imag magnitude larger than real
    logic rpos;  // real strictly positive
    logic ipos;  // imag strictly positive
    logic zero;  // both components zero
  } oct_t;

endpackage

// File: sv/vam_in_if.sv
// ----------------------------------------------------------------------------
// Vector input channel
// Valid/ready channel carrying one signed two-axis vector.
// ----------------------------------------------------------------------------
interface vam_in_if
  import vam_pkg::*;
#(
  parameter int unsigned SampleWidth = SAMPLE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] real_part;
  logic signed [SampleWidth-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

// File: sv/vam_out_if.sv
// ----------------------------------------------------------------------------
// Angle/amplitude output channel
// Valid/ready channel carrying one angle and amplitude result.
// ----------------------------------------------------------------------------
interface vam_out_if
  import vam_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [ANGLE_WIDTH-1:0] angle;
  logic [AMP_WIDTH-1:0]   amplitude;

  modport source (output valid, output angle, output amplitude, input ready);
  modport sink   (input valid, input angle, input amplitude, output ready);
endinterface

// File: sv/vam_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vam_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/vam_div.sv
// ----------------------------------------------------------------------------
// Ratio divider pipeline
// Restoring division of small*RatioSteps by large, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vam_div
  import vam_pkg::*;
#(
  parameter int unsigned SampleWidth = SAMPLE_WIDTH,
  parameter int unsigned RatioSteps  = RATIO_STEPS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [SampleWidth-1:0]                small_i,
  input  logic [SampleWidth-1:0]                large_i,
  input  oct_t                                  oct_i,
  output logic                                  valid_o,
  output logic [$clog2(RatioSteps+1)-1:0]       quot_o,
  output logic [SampleWidth-1:0]                large_o,
  output oct_t                                  oct_o
);
  localparam int unsigned QW = $clog2(RatioSteps + 1);
  localparam int unsigned RW = SampleWidth + QW;

  logic                   vld_q  [QW+1];
  logic [RW-1:0]          rem_q  [QW+1];
  logic [QW-1:0]          quot_q [QW+1];
  logic [SampleWidth-1:0] div_q  [QW+1];
  oct_t                   oct_q  [QW+1];

  // stage 0 is the unregistered entry point
  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = RW'(small_i) * RW'(RatioSteps);
  assign quot_q[0] = '0;
  assign div_q[0]  = large_i;
  assign oct_q[0]  = oct_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int unsigned Bit = QW - 1 - s;
    logic [RW-1:0] trial;
    logic          take;
    logic [RW-1:0] rem_d;
    logic [QW-1:0] quot_d;

    always_comb begin
      trial  = RW'(div_q[s]) << Bit;
      take   = rem_q[s] >= trial;
      rem_d  = take ? (rem_q[s] - trial) : rem_q[s];
      quot_d = quot_q[s];
      quot_d[Bit] = take;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        quot_q[s+1] <= quot_d;
        div_q[s+1]  <= div_q[s];
        oct_q[s+1]  <= oct_q[s];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = quot_q[QW];
  assign large_o = div_q[QW];
  assign oct_o   = oct_q[QW];
endmodule

// File: sv/vector_angle_magnitude_core.sv
// ----------------------------------------------------------------------------
// Vector angle and magnitude core
// Table-based atan2 and magnitude of a signed two-axis vector, pipelined.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                          | Transaction
// vec_i   | in  | real_part, imag_part (signed)    | valid && ready
// res_o   | out | angle, amplitude (16 bit each)   | valid && ready
//
// One vector per cycle while res_o is not stalled. Pipeline: input register,
// one divider stage per quotient bit, table read, multiply, output register.
// After reset a fill pass writes all RatioSteps+1 entries of both tables,
// with vec_i.ready low.
// A stalled res_o freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "vector_angle_magnitude_core_assert.svh"

module vector_angle_magnitude_core
  import vam_pkg::*;
#(
  parameter int unsigned RatioSteps  = RATIO_STEPS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vam_in_if.sink     vec_i,
  vam_out_if.source  res_o
);
  localparam int unsigned SampleWidth = SAMPLE_WIDTH;
  localparam int unsigned AW = $clog2(RatioSteps + 1);
  localparam int unsigned PW = SampleWidth + MAG_WIDTH;
  localparam real         Pi = 3.14159265358979323846;
  localparam real         InvSteps   = 1.0 / real'(RatioSteps);
  localparam real         CountScale = 32768.0 / Pi;

  typedef logic [ATAN_WIDTH-1:0] atan_tbl_t [RatioSteps+1];
  typedef logic [MAG_WIDTH-1:0]  mag_tbl_t  [RatioSteps+1];

  function automatic atan_tbl_t build_atan();
    atan_tbl_t t;
    real       r;
    for (int i = 0; i <= RatioSteps; i++) begin
      r    = $atan(real'(i) * InvSteps) * CountScale;
      t[i] = ATAN_WIDTH'($rtoi(r + 0.5));
    end
    return t;
  endfunction

  function automatic mag_tbl_t build_mag();
    mag_tbl_t t;
    real      x;
    for (int i = 0; i <= RatioSteps; i++) begin
      x    = real'(i) * InvSteps;
      t[i] = MAG_WIDTH'($rtoi($sqrt(1.0 + x * x) * 32768.0 + 0.5));
    end
    return t;
  endfunction

  localparam atan_tbl_t ATAN_TBL = build_atan();
  localparam mag_tbl_t  MAG_TBL  = build_mag();

  // ---------------- table fill after reset ----------------
  logic [AW-1:0] fill_cnt_q, fill_cnt_d;
  logic          fill_done_q, fill_done_d;

  always_comb begin
    fill_cnt_d  = fill_cnt_q;
    fill_done_d = fill_done_q;
    if (!fill_done_q) begin
      if (fill_cnt_q == AW'(RatioSteps)) begin
        fill_done_d = 1'b1;
      end else begin
        fill_cnt_d = fill_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q  <= '0;
      fill_done_q <= 1'b0;
    end else begin
      fill_cnt_q  <= fill_cnt_d;
      fill_done_q <= fill_done_d;
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_valid_q;

  assign adv         = !out_valid_q || res_o.ready;
  assign vec_i.ready = fill_done_q && adv;

  // ---------------- input stage: abs and octant ----------------
  logic [SampleWidth-1:0] ra, ia;
  logic                   rneg, ineg;
  oct_t                   in_oct;
  logic                   in_v_q;
  logic [SampleWidth-1:0] in_small_q, in_large_q;
  oct_t                   in_oct_q;

  always_comb begin
    rneg        = vec_i.real_part[SampleWidth-1];
    ineg        = vec_i.imag_part[SampleWidth-1];
    ra          = rneg ? SampleWidth'(-vec_i.real_part) : SampleWidth'(vec_i.real_part);
    ia          = ineg ? SampleWidth'(-vec_i.imag_part) : SampleWidth'(vec_i.imag_part);
    in_oct.swap = ia > ra;
    in_oct.rpos = !rneg && (vec_i.real_part != '0);
    in_oct.ipos = !ineg && (vec_i.imag_part != '0);
    in_oct.zero = (ra == '0) && (ia == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= vec_i.valid && vec_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_large_q <= in_oct.swap ? ia : ra;
      in_small_q <= in_oct.swap ? ra : ia;
      in_oct_q   <= in_oct;
    end
  end

  // ---------------- divider ----------------
  logic                   dv_v;
  logic [AW-1:0]          dv_quot;
  logic [SampleWidth-1:0] dv_large;
  oct_t                   dv_oct;
  logic [AW-1:0]          idx;

  vam_div #(
    .SampleWidth(SampleWidth),
    .RatioSteps (RatioSteps)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(in_v_q),
    .small_i(in_small_q),
    .large_i(in_large_q),
    .oct_i  (in_oct_q),
    .valid_o(dv_v),
    .quot_o (dv_quot),
    .large_o(dv_large),
    .oct_o  (dv_oct)
  );

  // zero vector reads entry 0
  assign idx = dv_oct.zero ? '0 : dv_quot;

  // ---------------- table read ----------------
  logic [ATAN_WIDTH-1:0]  atan_rd;
  logic [MAG_WIDTH-1:0]   mag_rd;
  logic                   rd_v_q;
  logic [SampleWidth-1:0] rd_large_q;
  oct_t                   rd_oct_q;

  vam_ram #(.Width(ATAN_WIDTH), .Depth(RatioSteps + 1)) u_atan_ram (
    .clk_i  (clk_i),
    .we_i   (!fill_done_q),
    .waddr_i(fill_cnt_q),
    .wdata_i(ATAN_TBL[fill_cnt_q]),
    .re_i   (adv),
    .raddr_i(idx),
    .rdata_o(atan_rd)
  );

  vam_ram #(.Width(MAG_WIDTH), .Depth(RatioSteps + 1)) u_mag_ram (
    .clk_i  (clk_i),
    .we_i   (!fill_done_q),
    .waddr_i(fill_cnt_q),
    .wdata_i(MAG_TBL[fill_cnt_q]),
    .re_i   (adv),
    .raddr_i(idx),
    .rdata_o(mag_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else if (adv) begin
      rd_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_large_q <= dv_large;
      rd_oct_q   <= dv_oct;
    end
  end

  // ---------------- multiply ----------------
  logic                  mu_v_q;
  logic [PW-1:0]         mu_prod_q;
  logic [ATAN_WIDTH-1:0] mu_tv_q;
  oct_t                  mu_oct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_v_q <= 1'b0;
    end else if (adv) begin
      mu_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_prod_q <= PW'(rd_large_q) * PW'(mag_rd);
      mu_tv_q   <= atan_rd;
      mu_oct_q  <= rd_oct_q;
    end
  end

  // ---------------- octant fold and output ----------------
  logic [ANGLE_WIDTH-1:0] tv, ang_d;
  logic [PW-1:0]          amp_wide;
  logic [AMP_WIDTH-1:0]   amp_d;
  logic [ANGLE_WIDTH-1:0] out_angle_q;
  logic [AMP_WIDTH-1:0]   out_amp_q;
  logic                   out_zero_q;

  always_comb begin
    tv       = ANGLE_WIDTH'(mu_tv_q);
    amp_wide = mu_prod_q >> FRAC_BITS;
    amp_d    = (|(amp_wide >> AMP_WIDTH)) ? '1 : amp_wide[AMP_WIDTH-1:0];
    if (!mu_oct_q.swap) begin
      if (mu_oct_q.rpos) ang_d = mu_oct_q.ipos ? tv : ('0 - tv);
      else               ang_d = mu_oct_q.ipos ? (ANG_HALF - tv) : (ANG_HALF + tv);
    end else begin
      if (mu_oct_q.rpos) ang_d = mu_oct_q.ipos ? (ANG_QUARTER - tv) : (ANG_3QUART + tv);
      else               ang_d = mu_oct_q.ipos ? (ANG_QUARTER + tv) : (ANG_3QUART - tv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_angle_q <= ang_d;
      out_amp_q   <= amp_d;
      out_zero_q  <= mu_oct_q.zero;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.angle     = out_angle_q;
  assign res_o.amplitude = out_amp_q;

  // ---------------- assertions ----------------
  `VAM_ASSERT_IMP(a_no_input_in_fill, vec_i.ready, fill_done_q, "input taken during table fill")
  `VAM_ASSERT_IMP(a_quot_range, dv_v && !dv_oct.zero, dv_quot <= AW'(RatioSteps), "ratio index above range")
  `VAM_ASSERT_IMP(a_zero_result, out_valid_q && out_zero_q, (out_angle_q == ANG_HALF) && (out_amp_q == '0), "zero vector result wrong")
  `VAM_ASSERT(a_stall_freeze, (!adv) |=> ($stable(in_v_q) && $stable(rd_v_q) && $stable(mu_v_q) && $stable(out_angle_q)), "pipeline moved while stalled")

endmodule
